### rtl/sm64_pkg.sv
package sm64_pkg;

  localparam int unsigned OperandW  = 64;
  localparam int unsigned FractionW = 53;
  localparam int unsigned IntDrawW  = 31;
  localparam int unsigned DividendW = 48;
  localparam int unsigned HalfW     = 32;
  localparam int unsigned DivSteps  = DividendW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  localparam logic [63:0] GoldenGamma = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MixMulA     = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MixMulB     = 64'h94D049BB133111EB;

  typedef enum logic [1:0] {
    OP_RESEED = 2'd0,
    OP_FRAC   = 2'd1,
    OP_INT    = 2'd2,
    OP_NOP    = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e                     opcode;
    logic signed [OperandW-1:0]  operand;
  } in_req_t;

  typedef struct packed {
    logic [FractionW-1:0] fraction;
    logic [IntDrawW-1:0]  int_draw;
  } out_req_t;

  // datapath commands
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD,
    DP_RESEED,
    DP_ADVANCE,
    DP_MUL,
    DP_ACC,
    DP_XS27,
    DP_XS31,
    DP_DIV_LOAD,
    DP_DIV_STEP,
    DP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] part;   // partial product: low*low, low*high, high*low
    logic       round;  // mix round: constant a or b
  } dp_cmd_t;

  typedef struct packed {
    opcode_e opcode;
    logic    bound_pos;
  } dp_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADVANCE,
    S_MUL,
    S_ACC,
    S_XS27,
    S_XS31,
    S_DIV_LOAD,
    S_DIV,
    S_DONE
  } ctrl_state_e;

  localparam logic [1:0] PartLast = 2'd2;

endpackage

### rtl/sm64_dp.sv
module sm64_dp
  import sm64_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_req_t  in_req_i,
  input  dp_cmd_t  cmd_i,
  output dp_sts_t  sts_o,
  output out_req_t out_req_o
);

  logic [63:0]          state_q, state_d;
  logic [63:0]          z_q, z_d;
  logic [63:0]          prod_q, prod_d;
  logic [63:0]          acc_q, acc_d;
  opcode_e              op_q, op_d;
  logic                 pos_q, pos_d;
  logic [OperandW-1:0]  operand_q, operand_d;
  logic [IntDrawW-1:0]  bound_q, bound_d;
  logic [DividendW-1:0] div_q, div_d;
  logic [IntDrawW-1:0]  rem_q, rem_d;
  out_req_t             res_q, res_d;

  logic [63:0]      adv;
  logic [63:0]      mul_const;
  logic [HalfW-1:0] mul_a, mul_b;
  logic [HalfW:0]   shifted;
  logic [HalfW:0]   trial;

  assign adv       = state_q + GoldenGamma;
  assign mul_const = cmd_i.round ? MixMulB : MixMulA;

  // one shared 32x32 multiplier, low 64 bits of the full product built in parts
  always_comb begin
    mul_a = z_q[HalfW-1:0];
    mul_b = mul_const[HalfW-1:0];
    case (cmd_i.part)
      2'd1:    mul_b = mul_const[63:HalfW];
      2'd2:    mul_a = z_q[63:HalfW];
      default: ;
    endcase
  end

  assign shifted = {1'b0, rem_q, div_q[DividendW-1]};
  assign trial   = shifted - {2'b00, bound_q};

  always_comb begin
    state_d   = state_q;
    z_d       = z_q;
    prod_d    = prod_q;
    acc_d     = acc_q;
    op_d      = op_q;
    pos_d     = pos_q;
    operand_d = operand_q;
    bound_d   = bound_q;
    div_d     = div_q;
    rem_d     = rem_q;
    res_d     = res_q;
    case (cmd_i.op)
      DP_LOAD: begin
        op_d      = in_req_i.opcode;
        operand_d = in_req_i.operand;
        pos_d     = !in_req_i.operand[OperandW-1] && (in_req_i.operand != '0);
        bound_d   = (in_req_i.operand[OperandW-2:IntDrawW] != '0) ? '1
                                                                  : in_req_i.operand[IntDrawW-1:0];
      end
      DP_RESEED:  state_d = operand_q;
      DP_ADVANCE: begin
        state_d = adv;
        z_d     = adv ^ (adv >> 30);
      end
      DP_MUL:     prod_d = mul_a * mul_b;
      DP_ACC: begin
        if (cmd_i.part == 2'd0) acc_d = prod_q;
        else acc_d = acc_q + {prod_q[HalfW-1:0], {HalfW{1'b0}}};
      end
      DP_XS27:    z_d = acc_q ^ (acc_q >> 27);
      DP_XS31:    z_d = acc_q ^ (acc_q >> 31);
      DP_DIV_LOAD: begin
        div_d = z_q[63:16];
        rem_d = '0;
      end
      DP_DIV_STEP: begin
        div_d = {div_q[DividendW-2:0], 1'b0};
        if (!trial[HalfW]) rem_d = trial[IntDrawW-1:0];
        else rem_d = shifted[IntDrawW-1:0];
      end
      DP_RESULT: begin
        res_d.fraction = (op_q == OP_FRAC) ? z_q[63:11] : '0;
        res_d.int_draw = (op_q == OP_INT && pos_q) ? rem_q : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GoldenGamma;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q       <= z_d;
    prod_q    <= prod_d;
    acc_q     <= acc_d;
    op_q      <= op_d;
    pos_q     <= pos_d;
    operand_q <= operand_d;
    bound_q   <= bound_d;
    div_q     <= div_d;
    rem_q     <= rem_d;
    res_q     <= res_d;
  end

  assign sts_o.opcode    = op_q;
  assign sts_o.bound_pos = pos_q;
  assign out_req_o       = res_q;

endmodule

### rtl/sm64_ctrl.sv
module sm64_ctrl
  import sm64_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e        state_q, state_d;
  logic [1:0]         part_q, part_d;
  logic               round_q, round_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      part_q      <= '0;
      round_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      part_q      <= part_d;
      round_q     <= round_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    part_d      = part_q;
    round_d     = round_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.op    = DP_IDLE;
    cmd_o.part  = part_q;
    cmd_o.round = round_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.opcode)
          OP_RESEED: begin
            cmd_o.op = DP_RESEED;
            state_d  = S_DONE;
          end
          OP_FRAC: state_d = S_ADVANCE;
          OP_INT:  state_d = sts_i.bound_pos ? S_ADVANCE : S_DONE;
          default: state_d = S_DONE;
        endcase
      end
      S_ADVANCE: begin
        cmd_o.op = DP_ADVANCE;
        part_d   = '0;
        round_d  = 1'b0;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = DP_MUL;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.op = DP_ACC;
        if (part_q == PartLast) begin
          part_d  = '0;
          state_d = round_q ? S_XS31 : S_XS27;
        end else begin
          part_d  = part_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_XS27: begin
        cmd_o.op = DP_XS27;
        round_d  = 1'b1;
        state_d  = S_MUL;
      end
      S_XS31: begin
        cmd_o.op = DP_XS31;
        state_d  = (sts_i.opcode == OP_INT) ? S_DIV_LOAD : S_DONE;
      end
      S_DIV_LOAD: begin
        cmd_o.op = DP_DIV_LOAD;
        cnt_d    = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = DP_DIV_STEP;
        if (cnt_q == DivCntW'(DivSteps - 1)) state_d = S_DONE;
        else cnt_d = cnt_q + 1'b1;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = DP_RESULT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/splitmix64_random_generator_core.sv
// splitmix64 generator with one 64-bit state word, reset to the golden gamma
// 0x9e3779b97f4a7c15. each request carries an opcode and a signed 64-bit
// operand and yields exactly one response, in order. reseed loads the operand
// bit pattern into the state and answers with zeros. a fraction draw adds the
// golden gamma, mixes the state and returns the top 53 mixed bits (value / 2^53
// in [0,1)). an integer draw with bound n returns (mix >> 16) mod n, with n
// saturated to 2^31-1; a bound of zero or below answers zero and leaves the
// state alone, as does the unused opcode. the two mix multiplies run on one
// shared 32x32 multiplier, three partial products each with a register after
// the multiplier, and the modulo runs one quotient bit per cycle over the
// 48-bit dividend. one request is in flight at a time; a finished response
// sits in the output register, so the next request is taken while it waits.

module splitmix64_random_generator_core
  import sm64_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_req_o
);

  // command and status between sequencer and datapath
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // sequencer: decode, multiply parts, xor-shift rounds, divide steps
  sm64_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  // generator state, mixer, serial remainder and response register
  sm64_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (dp_cmd),
    .sts_o     (dp_sts),
    .out_req_o (out_req_o)
  );

endmodule

### verif/sm64_draw_check.sv
module sm64_draw_check
  import sm64_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_req_t     in_req_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_req_t    out_req_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  localparam logic [63:0] BoundCeil = 64'h0000_0000_7FFF_FFFF;

  logic [63:0] gen_word;
  out_req_t    draw_q[$];
  int unsigned fails;

  // two xor-shift-multiply rounds and a final xor-shift
  function automatic logic [63:0] mix_word(input logic [63:0] z);
    z = (z ^ (z >> 30)) * MixMulA;
    z = (z ^ (z >> 27)) * MixMulB;
    return z ^ (z >> 31);
  endfunction

  task automatic predict_draw(input in_req_t req, output out_req_t res);
    logic [63:0] arg;
    logic [63:0] bound;
    logic [63:0] mixed;
    arg = req.operand;
    res = '0;
    case (req.opcode)
      OP_RESEED: gen_word = arg;
      OP_FRAC: begin
        gen_word = gen_word + GoldenGamma;
        mixed = mix_word(gen_word);
        res.fraction = mixed[63:11];
      end
      OP_INT: begin
        // non-positive bound: no advance, zero draw
        if (!arg[63] && arg != '0) begin
          bound = (arg > BoundCeil) ? BoundCeil : arg;
          gen_word = gen_word + GoldenGamma;
          mixed = mix_word(gen_word);
          res.int_draw = IntDrawW'((mixed >> 16) % bound);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_req_t want;
    if (!rst_ni) begin
      gen_word = GoldenGamma;
      draw_q.delete();
      fails = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      // response first: it always belongs to an earlier request
      if (out_valid_i && out_ready_i) begin
        if (draw_q.size() == 0) begin
          $display("%0t: unexpected response, fraction %h int_draw %h", $time,
                   out_req_i.fraction, out_req_i.int_draw);
          fails++;
        end else begin
          want = draw_q.pop_front();
          if (out_req_i.fraction !== want.fraction) begin
            $display("%0t: fraction mismatch, expected %h actual %h", $time,
                     want.fraction, out_req_i.fraction);
            fails++;
          end
          if (out_req_i.int_draw !== want.int_draw) begin
            $display("%0t: int_draw mismatch, expected %h actual %h", $time,
                     want.int_draw, out_req_i.int_draw);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_draw(in_req_i, want);
        draw_q.push_back(want);
      end
      pending_o <= draw_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

### verif/tb.sv
module tb;
  import sm64_pkg::*;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_req_t     in_req = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_req_t    out_req;
  logic        in_taken;
  int unsigned pending;
  int unsigned fail_count;

  // sender burst bookkeeping
  int unsigned burst_left = 0;
  int unsigned gap_len;

  // receiver stall pattern
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  splitmix64_random_generator_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_req_o  (out_req)
  );

  sm64_draw_check u_draw_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_req_i   (out_req),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // request acceptance seen at the rising edge, read back at the falling edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
    end
  end

  // receiver: switches between always ready, coin flip, mostly stalled and
  // a periodic one-in-eight stall, each mode held for a random stretch
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((stall_left % 8) != 0);
    endcase
  end

  // one request: opens a new burst (with its gap) when the last one ran out,
  // then holds valid until the request is accepted
  task automatic issue(input opcode_e op, input logic [63:0] arg);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      case ($urandom_range(0, 7))
        0, 1:    gap_len = 0;
        2:       gap_len = $urandom_range(20, 90);
        default: gap_len = $urandom_range(1, 6);
      endcase
      if (gap_len != 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(negedge clk_i);
      end
    end
    burst_left--;
    in_req   <= '{opcode: op, operand: arg};
    in_valid <= 1'b1;
    do @(negedge clk_i); while (!in_taken);
  endtask

  // hold off the sender until every response has come back
  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // random 64-bit word
  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [63:0] arg;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: draws straight from the reset state, extreme seeds,
    // saturating, exact-ceiling and non-positive bounds, the unused opcode
    issue(OP_FRAC, 64'd0);
    issue(OP_INT, 64'd1);
    issue(OP_INT, 64'd2);
    issue(OP_RESEED, 64'd0);
    issue(OP_FRAC, 64'd0);
    issue(OP_INT, 64'h7FFF_FFFF_FFFF_FFFF);
    issue(OP_RESEED, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(OP_FRAC, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(OP_INT, 64'h0000_0000_7FFF_FFFF);
    issue(OP_INT, 64'h0000_0000_8000_0000);
    issue(OP_INT, 64'h0000_0000_7FFF_FFFE);
    issue(OP_INT, 64'd0);
    issue(OP_INT, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(OP_INT, 64'h8000_0000_0000_0000);
    issue(OP_FRAC, 64'h8000_0000_0000_0000);
    issue(OP_NOP, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(OP_NOP, 64'd0);
    issue(OP_RESEED, 64'h8000_0000_0000_0000);
    issue(OP_INT, 64'd3);
    issue(OP_RESEED, 64'h7FFF_FFFF_FFFF_FFFF);
    issue(OP_FRAC, 64'd0);
    issue(OP_INT, 64'd65536);
    drain();

    // random traffic, with a full drain every few hundred requests
    for (int n = 0; n < 1900; n++) begin
      case ($urandom_range(0, 19))
        0, 1: issue(OP_RESEED, rand_word());
        2, 3, 4, 5, 6, 7, 8: issue(OP_FRAC, rand_word());
        9, 10, 11: issue(OP_INT, 64'($urandom_range(1, 16)));
        12, 13: issue(OP_INT, 64'($urandom_range(1, 32'h7FFF_FFFF)));
        14: begin
          // positive bound above the ceiling
          arg = rand_word();
          arg[63] = 1'b0;
          arg[62:31] = arg[62:31] | 32'h1;
          issue(OP_INT, arg);
        end
        15: issue(OP_INT, ($urandom_range(0, 1) != 0) ? 64'h7FFF_FFFF : 64'h8000_0000);
        16: begin
          // zero or negative bound
          arg = rand_word();
          arg[63] = 1'b1;
          issue(OP_INT, ($urandom_range(0, 3) == 0) ? 64'd0 : arg);
        end
        17: issue(OP_INT, rand_word());
        default: issue(OP_NOP, rand_word());
      endcase
      if (n % 400 == 399) drain();
    end

    // wait for the tail, then give a late stray response time to show up
    drain();
    repeat (80) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #18000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

### filelist.f
rtl/sm64_pkg.sv
rtl/sm64_dp.sv
rtl/sm64_ctrl.sv
rtl/splitmix64_random_generator_core.sv
verif/sm64_draw_check.sv
verif/tb.sv
